### rtl/gelu_bf16_activation_core_defines.svh
// ---------------------------------------------------------------------------
// gelu bf16 activation core assertion macros
// implication checks on the core clock with reset disable
// ---------------------------------------------------------------------------
`ifndef GELU_BF16_ACTIVATION_CORE_DEFINES_SVH
`define GELU_BF16_ACTIVATION_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define GELU_ASSERT_IMP(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> c) \
    else $error("gelu core check failed");
// next-cycle implication
`define GELU_ASSERT_NXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> c) \
    else $error("gelu core check failed");
`else
`define GELU_ASSERT_IMP(lbl, clk, rst, a, c)
`define GELU_ASSERT_NXT(lbl, clk, rst, a, c)
`endif

`endif

### rtl/gelu_pkg.sv
// ---------------------------------------------------------------------------
// gelu_pkg
// fixed-point constants, root table and sideband type of the gelu bf16 core
// ---------------------------------------------------------------------------
package gelu_pkg;

  localparam logic [63:0] K31_FULL =
    (64'd7978845608 * 64'd2147483648 + 64'd5000000000) / 64'd10000000000;
  localparam logic [63:0] A32_FULL =
    (64'd44715 * 64'd4294967296 + 64'd500000) / 64'd1000000;
  localparam logic [63:0] L30_FULL =
    (64'd14426950409 * 64'd1073741824 + 64'd5000000000) / 64'd10000000000;

  localparam logic [30:0] K31 = K31_FULL[30:0];
  localparam logic [27:0] A32 = A32_FULL[27:0];
  localparam logic [30:0] L30 = L30_FULL[30:0];
  localparam logic [30:0] ONE30 = 31'd1 << 30;

  localparam logic [15:0] BF_QNAN = 16'h7FC0;
  localparam logic [15:0] BF_PINF = 16'h7F80;

  typedef logic [24:1][30:0] root_tbl_t;

  // per-item data that rides along the whole pipeline
  typedef struct packed {
    logic        neg;
    logic [7:0]  msig;
    logic [7:0]  e;
    logic        spec;
    logic [15:0] spec_bits;
  } side_t;

  function automatic logic [31:0] isqrt(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bt;
    rem = v;
    res = '0;
    bt  = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (rem >= res + bt) begin
        rem = rem - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res[31:0];
  endfunction

  // c_i = 2^(-2^-i) in q.30
  function automatic root_tbl_t make_roots();
    root_tbl_t   tbl;
    logic [63:0] c;
    c = 64'd1 << 29;
    for (int i = 1; i <= 24; i++) begin
      c = {32'd0, isqrt(c << 30)};
      tbl[i] = c[30:0];
    end
    return tbl;
  endfunction

  localparam root_tbl_t ROOT_C = make_roots();

endpackage

### rtl/gelu_bf16_activation_core.sv
// ---------------------------------------------------------------------------
// gelu_bf16_activation_core
// bfloat16 gelu, tanh form, as a fixed-latency pipeline
// ---------------------------------------------------------------------------
// One bf16 value is taken in every cycle that start is high (busy stays low),
// and its gelu appears on y_bits with done high for one cycle per result, in
// order. The pipeline holds the 24 root-multiply stages of the exp unit and
// the 31 one-bit stages of the restoring divider that forms the quotient.
// Results cannot be held off, so they must be captured when done is high.
module gelu_bf16_activation_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] x_bits,
  output logic        done,
  output logic [15:0] y_bits
);
  import gelu_pkg::*;
  `include "gelu_bf16_activation_core_defines.svh"

  localparam int NR = 24;
  localparam int ND = 31;

  assign busy = 1'b0;

  // decode
  logic        s1_vld;
  side_t       s1_side;
  logic [26:0] s1_xq;
  side_t       dec_side;
  logic [26:0] dec_xq;

  always_comb begin
    logic [7:0] ex;
    logic [7:0] ee;
    logic [7:0] msig;
    logic [7:0] sh;
    ex   = x_bits[14:7];
    msig = {ex != 8'd0, x_bits[6:0]};
    ee   = (ex == 8'd0) ? 8'd1 : ex;
    dec_side.neg       = x_bits[15];
    dec_side.msig      = msig;
    dec_side.e         = ee;
    dec_side.spec      = 1'b1;
    dec_side.spec_bits = {x_bits[15], 15'd0};
    if (ex == 8'hFF) begin
      dec_side.spec_bits = (x_bits[6:0] != 7'd0) ? BF_QNAN :
                           (x_bits[15] ? 16'h0000 : BF_PINF);
    end else if (ex >= 8'd130) begin
      dec_side.spec_bits = x_bits[15] ? 16'h0000 : x_bits;
    end else if (msig != 8'd0) begin
      dec_side.spec = 1'b0;
    end
    if (ee >= 8'd110) begin
      sh     = ee - 8'd110;
      dec_xq = 27'(msig) << sh[4:0];
    end else begin
      sh     = 8'd110 - ee;
      dec_xq = (sh >= 8'd8) ? 27'd0 : 27'(msig >> sh[2:0]);
    end
  end

  // polynomial front end
  logic        s2_vld, s3_vld, s4_vld, s5_vld;
  side_t       s2_side, s3_side, s4_side, s5_side;
  logic [26:0] s2_xq, s3_xq;
  logic [29:0] s2_x2;
  logic [32:0] s3_x3;
  logic [28:0] s4_pp;
  logic [29:0] s5_w;
  logic [53:0] p_x2;
  logic [56:0] p_x3;
  logic [60:0] p_a;
  logic [59:0] p_w;
  logic [60:0] p_t;

  assign p_x2 = 54'(s1_xq) * 54'(s1_xq);
  assign p_x3 = 57'(s2_x2) * 57'(s2_xq);
  assign p_a  = 61'(s3_x3) * 61'(A32);
  assign p_w  = 60'(s4_pp) * 60'(K31);
  assign p_t  = 61'(s5_w) * 61'(L30);

  // exp(-w) as 2^-n * r, one root per stage
  logic        rv [0:NR];
  logic [30:0] rr [0:NR];
  logic [23:0] rf [0:NR];
  logic [6:0]  rn [0:NR];
  side_t       rs [0:NR];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
      s4_vld <= 1'b0;
      s5_vld <= 1'b0;
      rv[0]  <= 1'b0;
    end else begin
      s1_vld <= start && !busy;
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;
      s4_vld <= s3_vld;
      s5_vld <= s4_vld;
      rv[0]  <= s5_vld;
    end
  end

  always_ff @(posedge clk) begin
    s1_side <= dec_side;
    s1_xq   <= dec_xq;
    s2_side <= s1_side;
    s2_xq   <= s1_xq;
    s2_x2   <= p_x2[53:24];
    s3_side <= s2_side;
    s3_xq   <= s2_xq;
    s3_x3   <= p_x3[56:24];
    s4_side <= s3_side;
    s4_pp   <= 29'(s3_xq) + p_a[60:32];
    s5_side <= s4_side;
    s5_w    <= p_w[59:30];
    rs[0]   <= s5_side;
    rr[0]   <= ONE30;
    rn[0]   <= p_t[60:54];
    rf[0]   <= p_t[53:30];
  end

  for (genvar i = 1; i <= NR; i++) begin : g_root
    logic [61:0] prod;
    assign prod = 62'(rr[i-1]) * 62'(ROOT_C[i]);
    always_ff @(posedge clk) begin
      if (rst) begin
        rv[i] <= 1'b0;
      end else begin
        rv[i] <= rv[i-1];
      end
    end
    always_ff @(posedge clk) begin
      rr[i] <= rf[i-1][NR-i] ? prod[60:30] : rr[i-1];
      rf[i] <= rf[i-1];
      rn[i] <= rn[i-1];
      rs[i] <= rs[i-1];
    end
  end

  // denominator 1 + exp(-w) and restoring divider, one quotient bit per stage
  logic        dv   [0:ND];
  logic [31:0] drem [0:ND];
  logic [30:0] dlow [0:ND];
  logic [30:0] dq   [0:ND];
  logic [31:0] dd   [0:ND];
  logic [6:0]  de2  [0:ND];
  side_t       ds   [0:ND];
  logic [31:0] den;
  logic [60:0] num;

  always_comb begin
    den = (32'd1 << 30) +
          ((rn[NR] >= 7'd31) ? 32'd0 : 32'(rr[NR] >> rn[NR]));
    num = rs[NR].neg ? {rr[NR][30:0], 30'd0} : (61'd1 << 60);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else begin
      dv[0] <= rv[NR];
    end
  end

  always_ff @(posedge clk) begin
    drem[0] <= 32'(num[60:31]);
    dlow[0] <= num[30:0];
    dq[0]   <= '0;
    dd[0]   <= den;
    de2[0]  <= rs[NR].neg ? rn[NR] : 7'd0;
    ds[0]   <= rs[NR];
  end

  for (genvar j = 1; j <= ND; j++) begin : g_div
    logic [32:0] trial;
    logic        ge;
    assign trial = {drem[j-1], dlow[j-1][30]};
    assign ge    = trial >= {1'b0, dd[j-1]};
    always_ff @(posedge clk) begin
      if (rst) begin
        dv[j] <= 1'b0;
      end else begin
        dv[j] <= dv[j-1];
      end
    end
    always_ff @(posedge clk) begin
      drem[j] <= ge ? 32'(trial - {1'b0, dd[j-1]}) : trial[31:0];
      dlow[j] <= dlow[j-1] << 1;
      dq[j]   <= {dq[j-1][29:0], ge};
      dd[j]   <= dd[j-1];
      de2[j]  <= de2[j-1];
      ds[j]   <= ds[j-1];
    end
  end

  // scale, normalize and round to bf16
  logic              m_vld, l_vld, h_vld;
  side_t             m_side, l_side, h_side;
  logic [38:0]       m_mag, l_mag;
  logic signed [9:0] m_p;
  logic [5:0]        l_sh;
  logic [7:0]        l_expf, h_expf;
  logic [8:0]        h_m;
  logic              h_rnd;
  logic [5:0]        lz_msb;
  logic [5:0]        lz_sh;
  logic [7:0]        lz_expf;
  logic [8:0]        sh_m;
  logic              sh_rnd;
  logic [15:0]       y_next;

  always_comb begin
    logic signed [9:0] be;
    logic signed [9:0] shr;
    lz_msb = '0;
    for (int b = 0; b < 39; b++) begin
      if (m_mag[b]) begin
        lz_msb = 6'(b);
      end
    end
    be = $signed({4'd0, lz_msb}) + m_p + 10'sd127;
    if (be > 10'sd0) begin
      shr     = $signed({4'd0, lz_msb}) - 10'sd7;
      lz_expf = 8'(be - 10'sd1);
    end else begin
      shr     = -10'sd133 - m_p;
      lz_expf = 8'd0;
    end
    lz_sh = (shr > 10'sd40) ? 6'd40 : shr[5:0];
  end

  always_comb begin
    logic [39:0] mag40;
    logic [39:0] mfull;
    logic [39:0] rem;
    logic [39:0] half;
    mag40  = {1'b0, l_mag};
    mfull  = mag40 >> l_sh;
    rem    = mag40 & ((40'd1 << l_sh) - 40'd1);
    half   = 40'd1 << (l_sh - 6'd1);
    sh_m   = mfull[8:0];
    sh_rnd = (rem > half) || ((rem == half) && mfull[0]);
  end

  always_comb begin
    logic [15:0] sum;
    sum = {1'b0, h_expf, 7'd0} + 16'(h_m) + 16'(h_rnd);
    if (sum >= BF_PINF) begin
      sum = BF_PINF;
    end
    y_next = h_side.spec ? h_side.spec_bits : {h_side.neg, sum[14:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld <= 1'b0;
      l_vld <= 1'b0;
      h_vld <= 1'b0;
      done  <= 1'b0;
    end else begin
      m_vld <= dv[ND];
      l_vld <= m_vld;
      h_vld <= l_vld;
      done  <= h_vld;
    end
  end

  always_ff @(posedge clk) begin
    m_side <= ds[ND];
    m_mag  <= 39'(ds[ND].msig) * 39'(dq[ND]);
    m_p    <= $signed({2'd0, ds[ND].e}) - 10'sd164 - $signed({3'd0, de2[ND]});
    l_side <= m_side;
    l_mag  <= m_mag;
    l_sh   <= lz_sh;
    l_expf <= lz_expf;
    h_side <= l_side;
    h_m    <= sh_m;
    h_rnd  <= sh_rnd;
    h_expf <= l_expf;
    y_bits <= y_next;
  end

  // truncation in the root table and products can put r a few lsbs under one half
  `GELU_ASSERT_IMP(a_fixed_latency, clk, rst, start, ##66 done)
  `GELU_ASSERT_NXT(a_no_spurious_done, clk, rst, !h_vld, !done)
  `GELU_ASSERT_IMP(a_root_range, clk, rst, rv[NR],
                   (rr[NR] <= ONE30) && (rr[NR] >= ((ONE30 >> 1) - 31'd256)))
  `GELU_ASSERT_IMP(a_den_range, clk, rst, dv[0],
                   (dd[0] >= (32'd1 << 30)) && (dd[0] <= (32'd1 << 31)))
  `GELU_ASSERT_IMP(a_quot_range, clk, rst, dv[ND], dq[ND] <= ONE30)

endmodule

### test/tb_gelu_bf16_activation_core.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_gelu_bf16_activation_core
// drives bf16 values into the gelu core and checks every result against a
// bit-exact fixed-point predictor; random gaps on the input side
// ---------------------------------------------------------------------------
module tb_gelu_bf16_activation_core;

  class gelu_scoreboard;
    logic [15:0]     expected_y[$];
    int              fails;
    longint unsigned roots[1:24];

    function new();
      longint unsigned c;
      fails = 0;
      c = 64'd1 << 29;
      for (int i = 1; i <= 24; i++) begin
        c = int_sqrt(c << 30);
        roots[i] = c;
      end
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned acc;
      longint unsigned b;
      acc = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= acc + b) begin
          v = v - (acc + b);
          acc = (acc >> 1) + b;
        end else begin
          acc = acc >> 1;
        end
        b = b >> 2;
      end
      return acc;
    endfunction

    // round mag * 2^p to bf16, nearest even, keeping subnormals
    function logic [15:0] round_bf16(bit neg, longint unsigned mag, int p);
      int              top;
      int              be;
      int              sh;
      longint unsigned m;
      longint unsigned rem;
      longint unsigned half;
      longint unsigned bits;
      if (mag == 0) return {neg, 15'd0};
      top = 63;
      while (mag[top] == 1'b0) top--;
      be = top + p + 127;
      sh = (be >= 1) ? (top - 7) : (-133 - p);
      if (sh <= 0) begin
        m = mag << (-sh);
      end else if (sh >= 64) begin
        m = 0;
      end else begin
        rem  = mag & ((64'd1 << sh) - 1);
        half = 64'd1 << (sh - 1);
        m    = mag >> sh;
        if (rem > half || (rem == half && m[0])) m++;
      end
      bits = (be >= 1) ? ((longint'(be - 1) << 7) + m) : m;
      if (bits >= 64'h7F80) bits = 64'h7F80;
      return {neg, bits[14:0]};
    endfunction

    function logic [15:0] gelu_of(logic [15:0] x);
      bit              neg;
      int              ex;
      int              n;
      longint unsigned sig;
      longint unsigned xq, x2, x3, pp, w, t, f, r, d, s;
      neg = x[15];
      ex  = int'(x[14:7]);
      if (ex == 255) return (x[6:0] != 0) ? gelu_pkg::BF_QNAN :
                             (neg ? 16'h0000 : gelu_pkg::BF_PINF);
      if (ex >= 130) return neg ? 16'h0000 : x;
      sig = (ex != 0) ? {57'd1, x[6:0]} : {57'd0, x[6:0]};
      if (ex == 0) ex = 1;
      if (ex >= 110) xq = sig << (ex - 110);
      else if (110 - ex >= 8) xq = 0;
      else xq = sig >> (110 - ex);
      x2 = (xq * xq) >> 24;
      x3 = (x2 * xq) >> 24;
      pp = xq + ((x3 * gelu_pkg::A32_FULL) >> 32);
      w  = (pp * gelu_pkg::K31_FULL) >> 30;
      t  = (w * gelu_pkg::L30_FULL) >> 30;
      n  = int'(t >> 24);
      f  = t & 64'hFFFFFF;
      r  = 64'd1 << 30;
      for (int i = 1; i <= 24; i++)
        if (f[24 - i]) r = (r * roots[i]) >> 30;
      d = (64'd1 << 30) + ((n >= 31) ? 64'd0 : (r >> n));
      if (neg) begin
        s = (r << 30) / d;
        return round_bf16(neg, sig * s, ex - 164 - n);
      end
      s = (64'd1 << 60) / d;
      return round_bf16(neg, sig * s, ex - 164);
    endfunction

    function void note_input(logic [15:0] x);
      expected_y.push_back(gelu_of(x));
    endfunction

    function void check_result(logic [15:0] y);
      logic [15:0] e;
      if (expected_y.size() == 0) begin
        $error("y_bits: unexpected result %h", y);
        fails++;
        return;
      end
      e = expected_y.pop_front();
      if (y !== e) begin
        $error("y_bits: expected %h actual %h", e, y);
        fails++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [15:0] x_bits = '0;
  logic        busy;
  logic        done;
  logic [15:0] y_bits;
  int          cycles = 0;
  bit          calm;

  gelu_scoreboard sb = new();

  gelu_bf16_activation_core i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .x_bits(x_bits), .done(done), .y_bits(y_bits)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(y_bits);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("tb_gelu_bf16_activation_core: FAIL");
      $finish;
    end
  end

  task automatic send_value(logic [15:0] v);
    int gap;
    gap = calm ? 0 : int'($urandom_range(0, 17));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start  <= 1'b1;
    x_bits <= v;
    do @(posedge clk); while (busy);
    sb.note_input(v);
  endtask

  function automatic logic [15:0] pick_random();
    logic [15:0] v;
    v = 16'($urandom());
    // mostly the fixed-point range, exponent 100..129
    if ($urandom_range(0, 9) < 8) v[14:7] = 8'($urandom_range(100, 129));
    return v;
  endfunction

  logic [15:0] directed[] = '{
    16'h0000, 16'h8000, 16'h7F80, 16'hFF80, 16'h7FC0, 16'hFFC1, 16'h7F81,
    16'h4100, 16'hC100, 16'h40FF, 16'hC0FF, 16'h0001, 16'h8001, 16'h007F,
    16'h807F, 16'h3380, 16'hB300, 16'h3F80, 16'hBF80, 16'h7F7F, 16'hFF7F,
    16'h4000, 16'hC080, 16'h3E80, 16'hC0A0
  };

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    calm = 1'b0;
    foreach (directed[i]) send_value(directed[i]);
    for (int k = 0; k < 1750; k++) begin
      // stretches of 150 values, each picked at random with or without input gaps
      if (k % 150 == 0) calm = ($urandom_range(0, 2) == 0);
      send_value(pick_random());
    end
    start <= 1'b0;
    while (sb.expected_y.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (sb.fails == 0) begin
      $display("tb_gelu_bf16_activation_core: PASS");
    end else begin
      $display("tb_gelu_bf16_activation_core: FAIL");
    end
    $finish;
  end

endmodule
